// ===== hw/rtl/cpmt_pkg.sv =====
// ----------------------------------------------------------------------------
// cpmt_pkg
// Shared codes, states and control types of the sorted key table.
// ----------------------------------------------------------------------------
package cpmt_pkg;

  localparam int KEY_IN_W = 32;
  localparam int POS_W    = 5;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } cpmt_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPD
  } cpmt_state_t;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic set_en;
  } cpmt_ctrl_t;

endpackage

// ===== hw/rtl/cpmt_in_if.sv =====
// ----------------------------------------------------------------------------
// cpmt_in_if
// Request channel: operation, key and position with valid/ready.
// ----------------------------------------------------------------------------
interface cpmt_in_if
  import cpmt_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                op;
  logic [KEY_IN_W-1:0] key;
  logic [POS_W-1:0]    position;

  modport source (output valid, op, key, position, input ready);
  modport sink   (input valid, op, key, position, output ready);
endinterface

// ===== hw/rtl/cpmt_out_if.sv =====
// ----------------------------------------------------------------------------
// cpmt_out_if
// Result channel: lookup flags with valid/ready.
// ----------------------------------------------------------------------------
interface cpmt_out_if;
  logic valid;
  logic ready;
  logic found;
  logic position_set;
  logic table_full;

  modport source (output valid, found, position_set, table_full, input ready);
  modport sink   (input valid, found, position_set, table_full, output ready);
endinterface

// ===== hw/rtl/cpmt_cell.sv =====
// ----------------------------------------------------------------------------
// cpmt_cell
// One slot of the sorted chain: key, position mask and compare flags.
// ----------------------------------------------------------------------------
module cpmt_cell
  import cpmt_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int KEY_W = 32,
  parameter int POSN  = 32,
  parameter int CNT_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cpmt_ctrl_t       ctrl,
  input  logic [KEY_W-1:0] cmp_key,
  input  logic [CNT_W-1:0] count,
  input  logic [KEY_W-1:0] new_key,
  input  logic [POSN-1:0]  new_bit,
  input  logic             left_ge,
  input  logic [KEY_W-1:0] left_key,
  input  logic [POSN-1:0]  left_mask,
  output logic [KEY_W-1:0] key_o,
  output logic [POSN-1:0]  mask_o,
  output logic             ge_o,
  output logic             eq_o,
  output logic             pset_o
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [POSN-1:0]  mask_r, mask_nxt;
  logic             ge_r, eq_r;
  logic             occupied;

  assign occupied = count > CNT_W'(IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ge_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (ctrl.cmp_en) begin
      ge_r <= !occupied || (key_r > cmp_key);
      eq_r <= occupied && (key_r == cmp_key);
    end
  end

  always_comb begin
    priority if (ctrl.ins_en && left_ge) begin
      key_nxt  = left_key;
      mask_nxt = left_mask;
    end else if (ctrl.ins_en && ge_r) begin
      key_nxt  = new_key;
      mask_nxt = new_bit;
    end else if (ctrl.set_en && eq_r) begin
      key_nxt  = key_r;
      mask_nxt = mask_r | new_bit;
    end else begin
      key_nxt  = key_r;
      mask_nxt = mask_r;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    mask_r <= mask_nxt;
  end

  assign key_o  = key_r;
  assign mask_o = mask_r;
  assign ge_o   = ge_r;
  assign eq_o   = eq_r;
  assign pset_o = eq_r && (|(mask_r & new_bit));

endmodule

// ===== hw/rtl/char_position_mask_table_unit.sv =====
// ----------------------------------------------------------------------------
// char_position_mask_table_unit
// Sorted table of character keys, each with a mask of phrase positions.
//
//   channel | dir | payload                          | transfer when
//   in_ch   | in  | op, key, position                | valid && ready
//   out_ch  | out | found, position_set, table_full  | valid && ready
//
// On transfer every cell compares its key with the request key in parallel;
// in the update state, once no held result blocks it, the hit flags are combined and
// the chain shifts up by one slot on insert or sets a mask bit on add.
// Synchronous reset empties the table; no clearing pass is needed.
// A result waits in the output register; a held result stalls the update
// cycle of the next item until it is taken.
// ----------------------------------------------------------------------------
module char_position_mask_table_unit
  import cpmt_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BYTES   = 4,
  parameter int POSITIONS   = 32
) (
  input logic        clk,
  input logic        rst_n,
  cpmt_in_if.sink    in_ch,
  cpmt_out_if.source out_ch
);

  localparam int KEY_W = (KEY_BYTES * 8 < KEY_IN_W) ? KEY_BYTES * 8 : KEY_IN_W;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  cpmt_state_t          state_r, state_nxt;
  cpmt_ctrl_t           ctrl;
  logic                 op_r;
  logic [KEY_W-1:0]     key_r;
  logic [POSITIONS-1:0] bit_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 found_r, pset_r, full_r;
  logic                 found_nxt, pset_nxt, full_nxt;
  logic                 in_xfer, commit, hit, pset, is_full;

  logic [TABLE_DEPTH-1:0] ge_vec, eq_vec, pset_vec;
  logic [KEY_W-1:0]       cell_key  [TABLE_DEPTH];
  logic [POSITIONS-1:0]   cell_mask [TABLE_DEPTH];

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign commit      = (state_r == ST_UPD) && (!out_valid_r || out_ch.ready);
  assign hit         = |eq_vec;
  assign pset        = |pset_vec;
  assign is_full     = (count_r == CNT_W'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= in_ch.op;
      key_r <= in_ch.key[KEY_W-1:0];
      bit_r <= POSITIONS'(1) << in_ch.position;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    pset_r  <= pset_nxt;
    full_r  <= full_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    found_nxt     = found_r;
    pset_nxt      = pset_r;
    full_nxt      = full_r;
    ctrl          = '0;
    unique case (state_r)
      ST_IDLE: begin
        ctrl.cmp_en = in_xfer;
        if (in_xfer) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (commit) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          found_nxt     = hit;
          pset_nxt      = (op_r == OP_QUERY) && pset;
          full_nxt      = (op_r == OP_ADD) && !hit && is_full;
          ctrl.set_en   = (op_r == OP_ADD) && hit;
          ctrl.ins_en   = (op_r == OP_ADD) && !hit && !is_full;
          if (ctrl.ins_en) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic                 left_ge;
    logic [KEY_W-1:0]     left_key;
    logic [POSITIONS-1:0] left_mask;

    if (i == 0) begin : g_first
      assign left_ge   = 1'b0;
      assign left_key  = '0;
      assign left_mask = '0;
    end else begin : g_rest
      assign left_ge   = ge_vec[i-1];
      assign left_key  = cell_key[i-1];
      assign left_mask = cell_mask[i-1];
    end

    cpmt_cell #(
      .IDX   (i),
      .KEY_W (KEY_W),
      .POSN  (POSITIONS),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .cmp_key   (in_ch.key[KEY_W-1:0]),
      .count     (count_r),
      .new_key   (key_r),
      .new_bit   (bit_r),
      .left_ge   (left_ge),
      .left_key  (left_key),
      .left_mask (left_mask),
      .key_o     (cell_key[i]),
      .mask_o    (cell_mask[i]),
      .ge_o      (ge_vec[i]),
      .eq_o      (eq_vec[i]),
      .pset_o    (pset_vec[i])
    );
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = found_r;
  assign out_ch.position_set = pset_r;
  assign out_ch.table_full   = full_r;

`ifndef SYNTHESIS
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |-> $onehot0(eq_vec))
    else $error("more than one cell matches the key");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins_en |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not advance entry count");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r && state_r == ST_IDLE)
    else $error("update did not produce a result");
`endif

endmodule

// ===== verif/tb_char_position_mask_table_unit.sv =====
// ----------------------------------------------------------------------------
// tb_char_position_mask_table_unit
// Drives add and query requests into the sorted key table: corner keys and
// positions first, then random traffic around stored keys, a fill up to the
// table depth and adds that bounce off the full table. A scoreboard tracks
// the sorted keys and their position masks and checks every lookup result
// in order, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_char_position_mask_table_unit;
  import cpmt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 256;
  localparam int KEY_BYTES   = 4;
  localparam int POSITIONS   = 32;
  localparam int NUM_ITEMS   = 1350;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN       = 20;
  localparam logic [KEY_IN_W-1:0] KEY_MASK =
      (KEY_BYTES >= 4) ? '1 : KEY_IN_W'((64'h1 << (8 * KEY_BYTES)) - 1);

  typedef struct packed {
    logic found;
    logic position_set;
    logic table_full;
  } lookup_t;

  class table_scoreboard;
    logic [KEY_IN_W-1:0]  keys[$];
    logic [POSITIONS-1:0] masks[$];
    lookup_t              pending[$];
    int errors;
    int checked;
    int dropped;

    function void note_request(cpmt_op_t op, logic [KEY_IN_W-1:0] key,
                               logic [POS_W-1:0] pos);
      int                   slot;
      logic                 hit;
      logic [KEY_IN_W-1:0]  k;
      logic [POSITIONS-1:0] pos_bit;
      lookup_t              r;
      k       = key & KEY_MASK;
      pos_bit = (int'(pos) < POSITIONS) ? (POSITIONS'(1) << pos) : '0;
      slot    = 0;
      while (slot < keys.size() && keys[slot] < k) slot++;
      hit = (slot < keys.size()) && (keys[slot] == k);
      r = '0;
      r.found = hit;
      if (op == OP_QUERY) begin
        if (hit) r.position_set = |(masks[slot] & pos_bit);
      end else if (hit) begin
        masks[slot] |= pos_bit;
      end else if (keys.size() >= TABLE_DEPTH) begin
        r.table_full = 1'b1;
        dropped++;
      end else begin
        keys.insert(slot, k);
        masks.insert(slot, pos_bit);
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic found, logic position_set, logic table_full);
      lookup_t r;
      if (pending.size() == 0) begin
        $error("result with nothing outstanding: found=%0b position_set=%0b table_full=%0b",
               found, position_set, table_full);
        errors++;
        return;
      end
      r = pending.pop_front();
      checked++;
      if (found !== r.found) begin
        $error("found: expected %0b, actual %0b", r.found, found);
        errors++;
      end
      if (position_set !== r.position_set) begin
        $error("position_set: expected %0b, actual %0b", r.position_set, position_set);
        errors++;
      end
      if (table_full !== r.table_full) begin
        $error("table_full: expected %0b, actual %0b", r.table_full, table_full);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  cpmt_in_if  in_ch ();
  cpmt_out_if out_ch ();

  char_position_mask_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BYTES  (KEY_BYTES),
    .POSITIONS  (POSITIONS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  table_scoreboard sb = new();

  int  sent;
  int  cycles;
  int  in_stalls;
  int  hold_left;
  bit  held_once;
  bit  steady;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_ADD;
    in_ch.key      = '0;
    in_ch.position = '0;
    out_ch.ready   = 1'b0;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.found, out_ch.position_set, out_ch.table_full);
      if (in_ch.valid && !in_ch.ready) in_stalls++;
      if (!held_once && sent >= 300) begin
        held_once = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 10);
      end
    end
  end

  task automatic send_item(cpmt_op_t op, logic [KEY_IN_W-1:0] key, logic [POS_W-1:0] pos);
    while (!steady && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.key      <= key;
    in_ch.position <= pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(op, key, pos);
    sent++;
  endtask

  function automatic logic [POS_W-1:0] pick_position();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return POS_W'($urandom_range(POSITIONS - 1));
    endcase
  endfunction

  function automatic logic [KEY_IN_W-1:0] pick_stored_key();
    if (sb.keys.size() == 0) return $urandom;
    return sb.keys[$urandom_range(sb.keys.size() - 1)];
  endfunction

  function automatic logic [KEY_IN_W-1:0] pick_mixed_key();
    case ($urandom_range(19))
      0:                return '0;
      1:                return '1;
      2, 3, 4:          return pick_stored_key() + 1;
      5, 6:             return pick_stored_key() - 1;
      7, 8, 9, 10, 11:  return $urandom;
      default:          return pick_stored_key();
    endcase
  endfunction

  initial begin
    int            peak;
    int            pick;
    steady = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_QUERY, 32'h0000_0000, 5'd0);
    send_item(OP_ADD,   32'h0000_0000, 5'd0);
    send_item(OP_ADD,   32'hFFFF_FFFF, 5'd31);
    send_item(OP_ADD,   32'h8000_0000, 5'd5);
    send_item(OP_ADD,   32'h0000_0001, 5'd31);
    send_item(OP_ADD,   32'h8000_0000, 5'd17);
    send_item(OP_ADD,   32'h8000_0000, 5'd5);
    send_item(OP_QUERY, 32'h8000_0000, 5'd5);
    send_item(OP_QUERY, 32'h8000_0000, 5'd17);
    send_item(OP_QUERY, 32'h8000_0000, 5'd6);
    send_item(OP_QUERY, 32'hFFFF_FFFF, 5'd31);
    send_item(OP_QUERY, 32'h0000_0000, 5'd0);
    send_item(OP_QUERY, 32'h0000_0000, 5'd31);
    send_item(OP_QUERY, 32'h7FFF_FFFF, 5'd0);
    send_item(OP_QUERY, 32'hFFFF_FFFE, 5'd31);
    send_item(OP_ADD,   32'h4142_0000, 5'd1);
    send_item(OP_ADD,   32'h4100_0000, 5'd0);
    send_item(OP_QUERY, 32'h4142_0000, 5'd1);
    send_item(OP_QUERY, 32'h4142_0001, 5'd1);
    send_item(OP_QUERY, 32'h5555_AAAA, 5'd16);

    for (int i = 0; i < 350; i++) begin
      steady = (i >= 150 && i < 250);
      send_item(cpmt_op_t'($urandom_range(1)), pick_mixed_key(), pick_position());
    end
    steady = 1'b0;

    while (sb.keys.size() < TABLE_DEPTH) begin
      if ($urandom_range(4) == 0)
        send_item(OP_QUERY, pick_mixed_key(), pick_position());
      else
        send_item(OP_ADD, $urandom, pick_position());
    end
    peak = sb.keys.size();

    while (sent < NUM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 35)      send_item(OP_ADD, $urandom, pick_position());
      else if (pick < 60) send_item(OP_ADD, pick_stored_key(), pick_position());
      else if (pick < 90) send_item(OP_QUERY, pick_stored_key(), pick_position());
      else                send_item(OP_QUERY, pick_mixed_key(), pick_position());
    end
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d requests, %0d results checked, table filled to %0d keys",
             sent, sb.checked, peak);
    $display("%0d adds dropped on a full table, %0d cycles of input backpressure",
             sb.dropped, in_stalls);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cpmt_pkg.sv
hw/rtl/cpmt_in_if.sv
hw/rtl/cpmt_out_if.sv
hw/rtl/cpmt_cell.sv
hw/rtl/char_position_mask_table_unit.sv
verif/tb_char_position_mask_table_unit.sv
